// ----- sv/mdrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrc_pkg
// Shared types, constants and the crc helper for the distance reply checker.
// ----------------------------------------------------------------------------
package mdrc_pkg;

   // number of sensors whose address may be selected
   localparam int SENSORS = 4;
   // number of address registers in the register map
   localparam int NUM_ADDR_REGS = 4;

   // crc-16 settings
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // expected header bytes
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] BYTE_COUNT_TWO    = 8'h02;

   // register reset values
   localparam logic [15:0] MIN_DIST_RESET = 16'd5;
   localparam logic [15:0] MAX_DIST_RESET = 16'd1300;
   localparam logic [15:0] NO_DISTANCE    = 16'hFFFF;

   // register indexes
   localparam logic [2:0] CSR_ADDR_SENSOR_0 = 3'd0;
   localparam logic [2:0] CSR_ADDR_SENSOR_1 = 3'd1;
   localparam logic [2:0] CSR_ADDR_SENSOR_2 = 3'd2;
   localparam logic [2:0] CSR_ADDR_SENSOR_3 = 3'd3;
   localparam logic [2:0] CSR_MIN_DISTANCE  = 3'd4;
   localparam logic [2:0] CSR_MAX_DISTANCE  = 3'd5;

   // frame status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ADDRESS  = 3'd1;
   localparam logic [2:0] ST_FUNCTION = 3'd2;
   localparam logic [2:0] ST_COUNT    = 3'd3;
   localparam logic [2:0] ST_CRC      = 3'd4;
   localparam logic [2:0] ST_RANGE    = 3'd5;

   // input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic [1:0] sensor_index;
   } req_type;

   // result beat
   typedef struct packed {
      logic [2:0]  frame_status;
      logic [15:0] distance;
      logic        distance_valid;
   } rsp_type;

   // register values seen by the parser
   typedef struct packed {
      logic [NUM_ADDR_REGS-1:0][7:0] address_sensor;
      logic [15:0]                   min_distance;
      logic [15:0]                   max_distance;
   } cfg_type;

   // one byte of crc-16, lsb first, reflected polynomial
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data_in);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data_in};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- sv/mdrc_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrc_csr
// Register file: sensor addresses and distance limits.
// ----------------------------------------------------------------------------
module mdrc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   output mdrc_pkg::cfg_type cfg
);

   mdrc_pkg::cfg_type cfg_ff, cfg_in;

   // always able to take a write
   assign csr_ready = 1'b1;

   // write decode, out-of-map indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mdrc_pkg::CSR_ADDR_SENSOR_0: cfg_in.address_sensor[0] = csr_data[7:0];
            mdrc_pkg::CSR_ADDR_SENSOR_1: cfg_in.address_sensor[1] = csr_data[7:0];
            mdrc_pkg::CSR_ADDR_SENSOR_2: cfg_in.address_sensor[2] = csr_data[7:0];
            mdrc_pkg::CSR_ADDR_SENSOR_3: cfg_in.address_sensor[3] = csr_data[7:0];
            mdrc_pkg::CSR_MIN_DISTANCE:  cfg_in.min_distance      = csr_data;
            mdrc_pkg::CSR_MAX_DISTANCE:  cfg_in.max_distance      = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_sensor[0] <= 8'd1;
         cfg_ff.address_sensor[1] <= 8'd2;
         cfg_ff.address_sensor[2] <= 8'd3;
         cfg_ff.address_sensor[3] <= 8'd4;
         cfg_ff.min_distance      <= mdrc_pkg::MIN_DIST_RESET;
         cfg_ff.max_distance      <= mdrc_pkg::MAX_DIST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/mdrc_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrc_parser
// Frame state, crc update and checks; flags a result on the seventh byte.
// ----------------------------------------------------------------------------
module mdrc_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat_ok,
   input  mdrc_pkg::req_type req,
   input  mdrc_pkg::cfg_type cfg,
   output logic              emit,
   output mdrc_pkg::rsp_type result
);

   // byte position codes
   localparam logic [2:0] POS_ADDR   = 3'd0;
   localparam logic [2:0] POS_FUNC   = 3'd1;
   localparam logic [2:0] POS_COUNT  = 3'd2;
   localparam logic [2:0] POS_DIST_H = 3'd3;
   localparam logic [2:0] POS_DIST_L = 3'd4;
   localparam logic [2:0] POS_CRC_L  = 3'd5;
   localparam logic [2:0] POS_CRC_H  = 3'd6;
   localparam logic [2:0] POS_IDLE   = 3'd7;

   logic [2:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  exp_addr_ff, exp_addr_in;
   logic [7:0]  dist_h_ff, dist_h_in;
   logic [7:0]  dist_l_ff, dist_l_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic [1:0]  sensor_sel;
   logic [2:0]  pos_cur;
   logic [15:0] crc_cur;
   logic [2:0]  err_cur;
   logic [7:0]  exp_cur;
   logic [15:0] dist_word;
   logic [15:0] rx_crc;
   logic [2:0]  final_err;

   // clamp sensor index into the populated range
   always_comb begin
      if (int'(req.sensor_index) >= mdrc_pkg::SENSORS) begin
         sensor_sel = 2'(mdrc_pkg::SENSORS - 1);
      end else begin
         sensor_sel = req.sensor_index;
      end
   end

   // frame start restarts the frame context
   always_comb begin
      if (req.frame_start) begin
         pos_cur = POS_ADDR;
         crc_cur = mdrc_pkg::CRC_INIT;
         err_cur = mdrc_pkg::ST_OK;
         exp_cur = cfg.address_sensor[sensor_sel];
      end else begin
         pos_cur = pos_ff;
         crc_cur = crc_ff;
         err_cur = err_ff;
         exp_cur = exp_addr_ff;
      end
   end

   // final checks on the last byte
   assign dist_word = {dist_h_ff, dist_l_ff};
   assign rx_crc    = {req.data_byte, crc_lo_ff};

   always_comb begin
      final_err = err_cur;
      if (final_err == mdrc_pkg::ST_OK && crc_cur != rx_crc) begin
         final_err = mdrc_pkg::ST_CRC;
      end
      if (final_err == mdrc_pkg::ST_OK &&
          (dist_word < cfg.min_distance || dist_word > cfg.max_distance)) begin
         final_err = mdrc_pkg::ST_RANGE;
      end
   end

   // per-byte next state
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      err_in      = err_ff;
      exp_addr_in = exp_addr_ff;
      dist_h_in   = dist_h_ff;
      dist_l_in   = dist_l_ff;
      crc_lo_in   = crc_lo_ff;
      emit        = 1'b0;
      if (beat_ok && (req.frame_start || pos_ff != POS_IDLE)) begin
         exp_addr_in = exp_cur;
         err_in      = err_cur;
         crc_in      = crc_cur;
         pos_in      = pos_cur + 3'd1;
         case (pos_cur)
            POS_ADDR: begin
               if (req.data_byte != exp_cur && err_cur == mdrc_pkg::ST_OK) begin
                  err_in = mdrc_pkg::ST_ADDRESS;
               end
            end
            POS_FUNC: begin
               if (req.data_byte != mdrc_pkg::FUNC_READ_HOLDING &&
                   err_cur == mdrc_pkg::ST_OK) begin
                  err_in = mdrc_pkg::ST_FUNCTION;
               end
            end
            POS_COUNT: begin
               if (req.data_byte != mdrc_pkg::BYTE_COUNT_TWO &&
                   err_cur == mdrc_pkg::ST_OK) begin
                  err_in = mdrc_pkg::ST_COUNT;
               end
            end
            POS_DIST_H: dist_h_in = req.data_byte;
            POS_DIST_L: dist_l_in = req.data_byte;
            POS_CRC_L:  crc_lo_in = req.data_byte;
            POS_CRC_H: begin
               err_in = final_err;
               pos_in = POS_IDLE;
               emit   = 1'b1;
            end
            default: pos_in = POS_IDLE;
         endcase
         // crc covers the header and distance bytes
         if (pos_cur <= POS_DIST_L) begin
            crc_in = mdrc_pkg::crc16_byte(crc_cur, req.data_byte);
         end
      end
   end

   // result payload
   always_comb begin
      result.frame_status   = final_err;
      result.distance_valid = (final_err == mdrc_pkg::ST_OK);
      result.distance       = (final_err == mdrc_pkg::ST_OK) ? dist_word
                                                            : mdrc_pkg::NO_DISTANCE;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_IDLE;
         crc_ff      <= mdrc_pkg::CRC_INIT;
         err_ff      <= mdrc_pkg::ST_OK;
         exp_addr_ff <= 8'h00;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         err_ff      <= err_in;
         exp_addr_ff <= exp_addr_in;
      end
   end

   // captured frame bytes
   always_ff @(posedge clock) begin
      dist_h_ff <= dist_h_in;
      dist_l_ff <= dist_l_in;
      crc_lo_ff <= crc_lo_in;
   end

endmodule

// ----- sv/modbus_distance_reply_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_distance_reply_checker_top
// Checks 7-byte Modbus RTU distance replies and reports status and distance.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_data  (byte, frame start, sensor)
//   rsp      out  rsp_valid/rsp_stall  rsp_data  (status, distance, valid)
//   csr      in   csr_valid/csr_ready  csr_index, csr_data
//
// One byte is taken per cycle while req_stall is low; the crc byte update and all
// checks are combinational between the frame state and the result register.
// A result appears in the cycle after the seventh byte of a frame is taken.
// Reset is synchronous; no clearing pass follows.
// req_stall is raised only while a result waits and rsp_stall is high.
// ----------------------------------------------------------------------------
module modbus_distance_reply_checker_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mdrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mdrc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);

   mdrc_pkg::cfg_type cfg;
   mdrc_pkg::rsp_type result;
   logic              emit;
   logic              beat_ok;

   logic              rsp_valid_ff, rsp_valid_in;
   mdrc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // register file
   mdrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input beat taken unless a held result is blocked
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign beat_ok   = req_valid & ~req_stall;

   mdrc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .beat_ok (beat_ok),
      .req     (req_data),
      .cfg     (cfg),
      .emit    (emit),
      .result  (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
